@@ rtl/mddr_pkg.sv @@
// Shared types and constants for the motor drive dead-reckoning unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package mddr_pkg;

   localparam int DATA_W    = 32;               // positions, distances, time
   localparam int LEVEL_W   = 16;               // signed Q1.15 intensity
   localparam int LEVEL_FRAC = 15;              // fraction bits of the intensity
   localparam int FRAC16_W  = 16;               // Q0.16 fraction bits
   localparam int FS_W      = 31;               // full speed register
   localparam int TIME_W    = 16;               // millisecond registers
   localparam int CSR_IDX_W = 3;

   // Serial multiplier: 31-bit multiplicand, 32-bit multiplier, one bit a cycle
   localparam int MUL_A_W   = FS_W;
   localparam int MUL_B_W   = DATA_W;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // Serial divider by one minute in milliseconds, one quotient bit a cycle
   localparam int MS_PER_MIN = 60000;
   localparam int REM_W      = $clog2(MS_PER_MIN);
   localparam int DIV_CNT_W  = $clog2(PROD_W);

   // Servo duty: (49152 + level + 5) / 10, the divide done by reciprocal
   localparam logic [LEVEL_W-1:0] SERVO_OFFSET = 16'd49157;
   localparam logic [LEVEL_W-1:0] DIV10_RECIP  = 16'd52429;
   localparam int                 DIV10_SHIFT  = 19;

   localparam logic signed [LEVEL_W-1:0] LEVEL_MOST_NEG = 16'sh8000;
   localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR    = 16'sh8001;

   localparam logic signed [DATA_W-1:0] INT_HI = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] INT_LO = 32'sh8000_0000;
   localparam logic [FS_W-1:0]          DIST_SAT = 31'h7FFF_FFFF;

   localparam logic signed [DATA_W-1:0] TRAVEL_MIN_RST = 32'sd0;
   localparam logic signed [DATA_W-1:0] TRAVEL_MAX_RST = 32'sd6553600;
   localparam logic [TIME_W-1:0]        UPDATE_PERIOD_RST = 16'd100;

   typedef enum logic {
      OP_DRIVE = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRAVEL_MIN    = 3'd0,
      CSR_TRAVEL_MAX    = 3'd1,
      CSR_FULL_SPEED    = 3'd2,
      CSR_COAST_TIME    = 3'd3,
      CSR_MIN_SPEED     = 3'd4,
      CSR_UPDATE_PERIOD = 3'd5,
      CSR_SERVO_MODE    = 3'd6
   } csr_idx_type;

endpackage

`default_nettype wire

@@ rtl/mddr_channels.sv @@
// Valid/ready channel interfaces for drive items and result items.
// Depends on mddr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mddr_req_if;
   import mddr_pkg::*;
   logic                       valid;
   logic                       ready;
   op_type                     op;
   logic signed [LEVEL_W-1:0]  drive_level;
   logic [DATA_W-1:0]          now_ms;
   logic                       min_switch;
   logic                       max_switch;

   modport source (output valid, op, drive_level, now_ms, min_switch, max_switch,
                   input ready);
   modport sink   (input valid, op, drive_level, now_ms, min_switch, max_switch,
                   output ready);
endinterface

interface mddr_rsp_if;
   import mddr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [LEVEL_W-1:0]         duty_forward;
   logic [LEVEL_W-1:0]         duty_reverse;
   logic signed [DATA_W-1:0]   est_position;
   logic                       running;
   logic signed [LEVEL_W-1:0]  applied_level;

   modport source (output valid, duty_forward, duty_reverse, est_position, running,
                   applied_level, input ready);
   modport sink   (input valid, duty_forward, duty_reverse, est_position, running,
                   applied_level, output ready);
endinterface

`default_nettype wire

@@ rtl/motor_drive_dead_reckoning_unit.sv @@
// Top level: signed motor drive with limit interlock and dead-reckoning position.
// Depends on mddr_pkg, mddr_channels, mddr_mul and mddr_div.
//
//   channel  direction  handshake        carries
//   req_ch   in         valid/ready      op, drive_level, now_ms, min/max_switch
//   rsp_ch   out        valid/ready      duties, est_position, running, level
//   csr_*    in         csr_we only      register index and write data
//
// A command that needs no travel update passes through accept, decode and emit.
// An integration step adds the speed, minimum-speed and distance products, quotient,
// sum and position; a stop with coast adds a coast product, quotient, sum, position.
// Reset is synchronous and sets control and configuration state only; no clearing pass.
// A result waits in the output register; the next item is still accepted and
// holds in its last stage until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module motor_drive_dead_reckoning_unit (
   input  logic                             clock,
   input  logic                             reset,
   mddr_req_if.sink                         req_ch,
   mddr_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [mddr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mddr_pkg::DATA_W-1:0]      csr_wdata
);
   import mddr_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_DECODE = 10'b00_0000_0010,
      ST_SPEED  = 10'b00_0000_0100,
      ST_MINSP  = 10'b00_0000_1000,
      ST_DIST   = 10'b00_0001_0000,
      ST_DIVIDE = 10'b00_0010_0000,
      ST_SUM    = 10'b00_0100_0000,
      ST_POS    = 10'b00_1000_0000,
      ST_CMUL   = 10'b01_0000_0000,
      ST_EMIT   = 10'b10_0000_0000
   } state_type;

   // configuration
   logic signed [DATA_W-1:0]  tmin_ff, tmin_in, tmax_ff, tmax_in;
   logic [FS_W-1:0]           fs_ff, fs_in;
   logic [TIME_W-1:0]         coast_ff, coast_in, msf_ff, msf_in, period_ff, period_in;
   logic                      servo_ff, servo_in;

   // control and architectural state
   state_type                 state_ff, state_in;
   logic                      running_ff, running_in, open_ff, open_in;
   logic                      close_ff, close_in, coast_ph_ff, coast_ph_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic signed [DATA_W-1:0]  pos_ff, pos_in, start_ff, start_in, dsum_ff, dsum_in;
   logic [DATA_W-1:0]         last_ff, last_in;
   logic                      mul_go_ff, mul_go_in, div_go_ff, div_go_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // item and datapath holding registers
   op_type                    op_ff, op_in;
   logic signed [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [DATA_W-1:0]         now_ff, now_in;
   logic                      swmin_ff, swmin_in, swmax_ff, swmax_in;
   logic [FS_W-1:0]           speed_ff, speed_in;
   logic signed [DATA_W:0]    step_ff, step_in;
   logic [MUL_A_W-1:0]        mul_a_ff, mul_a_in;
   logic [MUL_B_W-1:0]        mul_b_ff, mul_b_in;
   logic [PROD_W-1:0]         div_n_ff, div_n_in;
   logic [LEVEL_W-1:0]        fwd_ff, fwd_in, rev_ff, rev_in;
   logic signed [DATA_W-1:0]  pos_out_ff, pos_out_in;
   logic                      run_out_ff, run_out_in;
   logic signed [LEVEL_W-1:0] lvl_out_ff, lvl_out_in;

   // unit handshakes
   logic                      mul_done, div_done;
   logic [PROD_W-1:0]         mul_prod, div_quo;

   // combinational helpers
   logic signed [LEVEL_W-1:0] lvl_clamp, level_neg;
   logic                      at_min, at_max, lvl_zero, tick_due, gate, coast_on, int_end;
   logic [DATA_W-1:0]         elapsed;
   logic [LEVEL_FRAC-1:0]     mag;
   logic [FS_W-1:0]           minsp, dmag;
   logic                      dist_big;
   logic [DATA_W:0]           step_mag;
   logic signed [DATA_W:0]    step_calc;
   logic signed [DATA_W+1:0]  sum_wide;
   logic signed [DATA_W-1:0]  dsum_sat;
   logic signed [DATA_W:0]    pos_wide;
   logic signed [DATA_W-1:0]  pos_clamp;
   logic signed [LEVEL_W+1:0] servo_x;
   logic [DIV10_SHIFT+LEVEL_W-1:0] servo_prod;
   logic [LEVEL_W-1:0]        fwd_calc, rev_calc;

   mddr_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .go     (mul_go_ff),
      .mcand  (mul_a_ff),
      .mplier (mul_b_ff),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   mddr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go_ff),
      .dividend (div_n_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // drive decision
   assign lvl_clamp = (lvl_ff == LEVEL_MOST_NEG) ? LEVEL_FLOOR : lvl_ff;
   assign at_min    = swmin_ff || (pos_ff <= tmin_ff);
   assign at_max    = swmax_ff || (pos_ff >= tmax_ff);
   assign lvl_zero  = (lvl_clamp == '0) || (lvl_clamp[LEVEL_W-1] && at_min)
                    || (!lvl_clamp[LEVEL_W-1] && at_max);

   assign elapsed   = now_ff - last_ff;
   assign tick_due  = running_ff && open_ff && (elapsed >= DATA_W'(period_ff));

   assign level_neg = -level_ff;
   assign mag       = level_ff[LEVEL_W-1] ? level_neg[LEVEL_FRAC-1:0] : level_ff[LEVEL_FRAC-1:0];

   assign minsp     = mul_prod[FRAC16_W+FS_W-1:FRAC16_W];
   assign gate      = speed_ff >= minsp;
   assign coast_on  = (coast_ff != '0) && (fs_ff != '0);

   // distance step: saturate to the signed range outside the coast phase, then take the level's sign
   assign dist_big  = |div_quo[PROD_W-1:FS_W];
   assign dmag      = dist_big ? DIST_SAT : div_quo[FS_W-1:0];
   assign step_mag  = coast_ph_ff ? {1'b0, div_quo[DATA_W-1:0]} : {2'b00, dmag};
   assign step_calc = level_ff[LEVEL_W-1] ? -$signed(step_mag) : $signed(step_mag);

   assign sum_wide  = $signed({{2{dsum_ff[DATA_W-1]}}, dsum_ff})
                    + $signed({step_ff[DATA_W], step_ff});
   assign dsum_sat  = (sum_wide[DATA_W+1:DATA_W-1] == 3'b000
                      || sum_wide[DATA_W+1:DATA_W-1] == 3'b111) ? sum_wide[DATA_W-1:0]
                    : (sum_wide[DATA_W+1] ? INT_LO : INT_HI);

   assign pos_wide  = $signed({start_ff[DATA_W-1], start_ff})
                    + $signed({dsum_ff[DATA_W-1], dsum_ff});
   assign pos_clamp = (pos_wide < $signed({tmin_ff[DATA_W-1], tmin_ff})) ? tmin_ff
                    : (pos_wide > $signed({tmax_ff[DATA_W-1], tmax_ff})) ? tmax_ff
                    : pos_wide[DATA_W-1:0];

   // output duties
   assign servo_x    = $signed({2'b00, SERVO_OFFSET})
                     + $signed({{2{level_ff[LEVEL_W-1]}}, level_ff});
   assign servo_prod = (DIV10_SHIFT+LEVEL_W)'(servo_x[LEVEL_W:0])
                     * (DIV10_SHIFT+LEVEL_W)'(DIV10_RECIP);

   always_comb begin
      fwd_calc = '0;
      rev_calc = '0;
      if (servo_ff) begin
         fwd_calc = servo_prod[DIV10_SHIFT+LEVEL_W-1:DIV10_SHIFT];
      end else if (level_ff[LEVEL_W-1]) begin
         rev_calc = {mag, 1'b0};
      end else if (level_ff != '0) begin
         fwd_calc = {level_ff[LEVEL_FRAC-1:0], 1'b0};
      end
   end

   always_comb begin
      tmin_in      = tmin_ff;
      tmax_in      = tmax_ff;
      fs_in        = fs_ff;
      coast_in     = coast_ff;
      msf_in       = msf_ff;
      period_in    = period_ff;
      servo_in     = servo_ff;
      state_in     = state_ff;
      running_in   = running_ff;
      open_in      = open_ff;
      close_in     = close_ff;
      coast_ph_in  = coast_ph_ff;
      level_in     = level_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      dsum_in      = dsum_ff;
      last_in      = last_ff;
      mul_go_in    = 1'b0;
      div_go_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      lvl_in       = lvl_ff;
      now_in       = now_ff;
      swmin_in     = swmin_ff;
      swmax_in     = swmax_ff;
      speed_in     = speed_ff;
      step_in      = step_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      div_n_in     = div_n_ff;
      fwd_in       = fwd_ff;
      rev_in       = rev_ff;
      pos_out_in   = pos_out_ff;
      run_out_in   = run_out_ff;
      lvl_out_in   = lvl_out_ff;
      int_end      = 1'b0;

      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_TRAVEL_MIN:    tmin_in   = $signed(csr_wdata);
            CSR_TRAVEL_MAX:    tmax_in   = $signed(csr_wdata);
            CSR_FULL_SPEED:    fs_in     = csr_wdata[FS_W-1:0];
            CSR_COAST_TIME:    coast_in  = csr_wdata[TIME_W-1:0];
            CSR_MIN_SPEED:     msf_in    = csr_wdata[TIME_W-1:0];
            CSR_UPDATE_PERIOD: period_in = csr_wdata[TIME_W-1:0];
            CSR_SERVO_MODE:    servo_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.op;
               lvl_in   = req_ch.drive_level;
               now_in   = req_ch.now_ms;
               swmin_in = req_ch.min_switch;
               swmax_in = req_ch.max_switch;
               // limit switches reset the estimate, minimum wins
               if (req_ch.min_switch) begin
                  pos_in = tmin_ff;
               end else if (req_ch.max_switch) begin
                  pos_in = tmax_ff;
               end
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_EMIT;
            if (op_ff == OP_DRIVE) begin
               if (lvl_zero) begin
                  running_in = 1'b0;
                  if (running_ff && open_ff) begin
                     // keep the old level until the travel record is closed
                     close_in    = 1'b1;
                     coast_ph_in = 1'b0;
                     mul_go_in   = 1'b1;
                     mul_a_in    = fs_ff;
                     mul_b_in    = MUL_B_W'(mag);
                     state_in    = ST_SPEED;
                  end else begin
                     level_in = '0;
                  end
               end else begin
                  level_in   = lvl_clamp;
                  running_in = 1'b1;
                  if (!running_ff) begin
                     open_in  = 1'b1;
                     last_in  = now_ff;
                     dsum_in  = '0;
                     start_in = pos_ff;
                  end
               end
            end else if (tick_due) begin
               close_in    = 1'b0;
               coast_ph_in = 1'b0;
               mul_go_in   = 1'b1;
               mul_a_in    = fs_ff;
               mul_b_in    = MUL_B_W'(mag);
               state_in    = ST_SPEED;
            end
         end
         ST_SPEED: begin
            if (mul_done) begin
               speed_in  = mul_prod[LEVEL_FRAC+FS_W-1:LEVEL_FRAC];
               mul_go_in = 1'b1;
               mul_a_in  = fs_ff;
               mul_b_in  = MUL_B_W'(msf_ff);
               state_in  = ST_MINSP;
            end
         end
         ST_MINSP: begin
            if (mul_done) begin
               if (gate) begin
                  mul_go_in = 1'b1;
                  mul_a_in  = speed_ff;
                  mul_b_in  = elapsed;
                  state_in  = ST_DIST;
               end else begin
                  int_end = 1'b1;
               end
            end
         end
         ST_DIST, ST_CMUL: begin
            if (mul_done) begin
               div_go_in = 1'b1;
               div_n_in  = mul_prod;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               step_in  = step_calc;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            dsum_in  = dsum_sat;
            state_in = ST_POS;
         end
         ST_POS: begin
            pos_in = pos_clamp;
            if (coast_ph_ff) begin
               open_in     = 1'b0;
               level_in    = '0;
               close_in    = 1'b0;
               coast_ph_in = 1'b0;
               state_in    = ST_EMIT;
            end else begin
               int_end = 1'b1;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               fwd_in       = fwd_calc;
               rev_in       = rev_calc;
               pos_out_in   = pos_ff;
               run_out_in   = running_ff;
               lvl_out_in   = level_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // end of an integration step: stamp the time, then coast, close or just emit
      if (int_end) begin
         last_in = now_ff;
         if (close_ff && coast_on) begin
            mul_go_in   = 1'b1;
            mul_a_in    = fs_ff;
            mul_b_in    = MUL_B_W'(coast_ff);
            coast_ph_in = 1'b1;
            state_in    = ST_CMUL;
         end else if (close_ff) begin
            open_in  = 1'b0;
            level_in = '0;
            close_in = 1'b0;
            state_in = ST_EMIT;
         end else begin
            state_in = ST_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmin_ff      <= TRAVEL_MIN_RST;
         tmax_ff      <= TRAVEL_MAX_RST;
         fs_ff        <= '0;
         coast_ff     <= '0;
         msf_ff       <= '0;
         period_ff    <= UPDATE_PERIOD_RST;
         servo_ff     <= 1'b0;
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         open_ff      <= 1'b0;
         close_ff     <= 1'b0;
         coast_ph_ff  <= 1'b0;
         level_ff     <= '0;
         pos_ff       <= '0;
         start_ff     <= '0;
         dsum_ff      <= '0;
         last_ff      <= '0;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tmin_ff      <= tmin_in;
         tmax_ff      <= tmax_in;
         fs_ff        <= fs_in;
         coast_ff     <= coast_in;
         msf_ff       <= msf_in;
         period_ff    <= period_in;
         servo_ff     <= servo_in;
         state_ff     <= state_in;
         running_ff   <= running_in;
         open_ff      <= open_in;
         close_ff     <= close_in;
         coast_ph_ff  <= coast_ph_in;
         level_ff     <= level_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         dsum_ff      <= dsum_in;
         last_ff      <= last_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      lvl_ff     <= lvl_in;
      now_ff     <= now_in;
      swmin_ff   <= swmin_in;
      swmax_ff   <= swmax_in;
      speed_ff   <= speed_in;
      step_ff    <= step_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      div_n_ff   <= div_n_in;
      fwd_ff     <= fwd_in;
      rev_ff     <= rev_in;
      pos_out_ff <= pos_out_in;
      run_out_ff <= run_out_in;
      lvl_out_ff <= lvl_out_in;
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.duty_forward  = fwd_ff;
   assign rsp_ch.duty_reverse  = rev_ff;
   assign rsp_ch.est_position  = pos_out_ff;
   assign rsp_ch.running       = run_out_ff;
   assign rsp_ch.applied_level = lvl_out_ff;

   a_run_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && running_ff) |-> open_ff)
      else $error("motor running without an open travel record");
   a_mul_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_SPEED || state_ff == ST_MINSP
                    || state_ff == ST_DIST || state_ff == ST_CMUL))
      else $error("product arrived outside a multiply wait");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("quotient arrived outside the divide wait");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (!close_ff && !coast_ph_ff))
      else $error("stop sequence left pending at idle");

endmodule

`default_nettype wire

@@ rtl/mddr_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on mddr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mddr_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [mddr_pkg::MUL_A_W-1:0]  mcand,
   input  logic [mddr_pkg::MUL_B_W-1:0]  mplier,
   output logic                          done,
   output logic [mddr_pkg::PROD_W-1:0]   prod
);
   import mddr_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]        mcand_ff, mcand_in;
   logic [2*MUL_B_W-1:0]      acc_ff, acc_in;
   logic [MUL_B_W:0]          part_sum;

   // add the multiplicand into the upper half when the low bit is set
   assign part_sum = {1'b0, acc_ff[2*MUL_B_W-1:MUL_B_W]}
                   + (acc_ff[0] ? (MUL_B_W+1)'(mcand_ff) : '0);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (go) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         acc_in   = {{MUL_B_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         acc_in = {part_sum, acc_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff[PROD_W-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      go |-> !busy_ff)
      else $error("multiplier restarted while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("multiplier done held longer than a cycle");

endmodule

`default_nettype wire

@@ rtl/mddr_div.sv @@
// Bit-serial restoring divider by one minute in milliseconds.
// Depends on mddr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mddr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [mddr_pkg::PROD_W-1:0]  dividend,
   output logic                         done,
   output logic [mddr_pkg::PROD_W-1:0]  quotient
);
   import mddr_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [PROD_W-1:0]     quo_ff, quo_in;
   logic [REM_W:0]        rem_sh;
   logic                  fits;

   // bring down the next dividend bit and trial-subtract
   assign rem_sh = {rem_ff, quo_ff[PROD_W-1]};
   assign fits   = rem_sh >= (REM_W+1)'(MS_PER_MIN);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? REM_W'(rem_sh - (REM_W+1)'(MS_PER_MIN)) : rem_sh[REM_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(PROD_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      go |-> !busy_ff)
      else $error("divider restarted while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != '0) |-> rem_ff < REM_W'(MS_PER_MIN))
      else $error("divider remainder out of range");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than a cycle");

endmodule

`default_nettype wire

@@ test/drive_outcome_checker.sv @@
// Result checker for the motor drive dead-reckoning unit: follows register writes and
// accepted items, predicts every result and compares results in order of arrival.
// Depends on mddr_pkg and the channel interfaces of mddr_channels.
`timescale 1ns / 1ps

module drive_outcome_checker
   import mddr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   mddr_req_if                  req_mon,
   mddr_rsp_if                  rsp_mon,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   results_seen,
   output int                   outstanding
);

   typedef struct packed {
      logic [LEVEL_W-1:0]        duty_fwd;
      logic [LEVEL_W-1:0]        duty_rev;
      logic signed [DATA_W-1:0]  position;
      logic                      running;
      logic signed [LEVEL_W-1:0] level;
   } drive_outcome_type;

   drive_outcome_type outcome_queue[$];

   // register copies
   logic signed [DATA_W-1:0] tmin_q, tmax_q;
   logic [FS_W-1:0]          speed_q;
   logic [TIME_W-1:0]        coast_q, minfrac_q, period_q;
   logic                     servo_q;

   // drive and travel record
   logic                      running_q, open_q;
   logic signed [LEVEL_W-1:0] level_q;
   logic signed [DATA_W-1:0]  pos_q, start_q, dist_q;
   logic [DATA_W-1:0]         last_ms_q;

   function automatic logic signed [DATA_W-1:0] saturate_distance(longint v);
      if (v > longint'(INT_HI)) return INT_HI;
      if (v < longint'(INT_LO)) return INT_LO;
      return DATA_W'(v);
   endfunction

   // lower bound is tested first, so it wins on an inverted range
   function automatic logic signed [DATA_W-1:0] clamp_to_travel(longint v);
      if (v < longint'(tmin_q)) return tmin_q;
      if (v > longint'(tmax_q)) return tmax_q;
      return DATA_W'(v);
   endfunction

   function automatic void integrate_travel(logic [DATA_W-1:0] now);
      int                   mag;
      longint unsigned      speed, floor_speed, step_dist;
      longint               signed_dist;
      logic [DATA_W-1:0]    elapsed;
      mag = (level_q < 0) ? -int'(level_q) : int'(level_q);
      speed = (64'(speed_q) * 64'(mag)) >> LEVEL_FRAC;
      floor_speed = (64'(speed_q) * 64'(minfrac_q)) >> FRAC16_W;
      if (speed >= floor_speed) begin
         elapsed = now - last_ms_q;
         step_dist = speed * 64'(elapsed) / 64'(MS_PER_MIN);
         if (step_dist > 64'(INT_HI)) step_dist = 64'(INT_HI);
         signed_dist = (level_q < 0) ? -longint'(step_dist) : longint'(step_dist);
         dist_q = saturate_distance(longint'(dist_q) + signed_dist);
         pos_q = clamp_to_travel(longint'(start_q) + longint'(dist_q));
      end
      last_ms_q = now;
   endfunction

   function automatic void close_travel(logic [DATA_W-1:0] now);
      longint                   coast_dist;
      logic signed [DATA_W-1:0] landed;
      if (!open_q) return;
      integrate_travel(now);
      if (coast_q != 0 && speed_q != 0) begin
         coast_dist = longint'(64'(speed_q) * 64'(coast_q) / 64'(MS_PER_MIN));
         if (level_q < 0) coast_dist = -coast_dist;
         dist_q = saturate_distance(longint'(dist_q) + coast_dist);
         landed = clamp_to_travel(longint'(start_q) + longint'(dist_q));
         dist_q = saturate_distance(longint'(landed) - longint'(start_q));
         pos_q = landed;
      end
      open_q = 1'b0;
   endfunction

   function automatic drive_outcome_type predict_outcome(op_type op,
         logic signed [LEVEL_W-1:0] raw_level, logic [DATA_W-1:0] now,
         logic sw_min, logic sw_max);
      int                lvl;
      logic              at_min, at_max, was_running;
      logic [DATA_W-1:0] elapsed;
      drive_outcome_type o;
      // switches first; minimum overrides maximum
      if (sw_max) pos_q = tmax_q;
      if (sw_min) pos_q = tmin_q;
      if (op == OP_DRIVE) begin
         at_min = sw_min || (pos_q <= tmin_q);
         at_max = sw_max || (pos_q >= tmax_q);
         lvl = (raw_level == LEVEL_MOST_NEG) ? int'(LEVEL_FLOOR) : int'(raw_level);
         if ((lvl < 0 && at_min) || (lvl > 0 && at_max)) lvl = 0;
         was_running = running_q;
         if (lvl == 0) begin
            running_q = 1'b0;
            if (was_running) close_travel(now);
            level_q = '0;
         end else begin
            level_q = LEVEL_W'(lvl);
            running_q = 1'b1;
            if (!was_running) begin
               open_q = 1'b1;
               last_ms_q = now;
               dist_q = '0;
               start_q = pos_q;
            end
         end
      end else begin
         elapsed = now - last_ms_q;
         if (running_q && open_q && elapsed >= DATA_W'(period_q)) integrate_travel(now);
      end
      o.duty_fwd = '0;
      o.duty_rev = '0;
      if (servo_q) o.duty_fwd = LEVEL_W'((49152 + int'(level_q) + 5) / 10);
      else if (level_q > 0) o.duty_fwd = LEVEL_W'(int'(level_q) * 2);
      else if (level_q < 0) o.duty_rev = LEVEL_W'(-int'(level_q) * 2);
      o.position = pos_q;
      o.running = running_q;
      o.level = level_q;
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      if (fail_count < 40) $display("ERROR: result %0d: %s", results_seen, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      drive_outcome_type want;
      if (reset) begin
         tmin_q = TRAVEL_MIN_RST;
         tmax_q = TRAVEL_MAX_RST;
         speed_q = '0;
         coast_q = '0;
         minfrac_q = '0;
         period_q = UPDATE_PERIOD_RST;
         servo_q = 1'b0;
         running_q = 1'b0;
         open_q = 1'b0;
         level_q = '0;
         pos_q = '0;
         start_q = '0;
         dist_q = '0;
         last_ms_q = '0;
         fail_count = 0;
         results_seen = 0;
         outcome_queue.delete();
      end else begin
         // the result taken at this edge is older than any item taken at it
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (outcome_queue.size() == 0) begin
               report_mismatch("result with no item waiting");
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_mon.duty_forward !== want.duty_fwd)
                  report_mismatch($sformatf("duty_forward %0d, expected %0d",
                                            rsp_mon.duty_forward, want.duty_fwd));
               if (rsp_mon.duty_reverse !== want.duty_rev)
                  report_mismatch($sformatf("duty_reverse %0d, expected %0d",
                                            rsp_mon.duty_reverse, want.duty_rev));
               if (rsp_mon.est_position !== want.position)
                  report_mismatch($sformatf("est_position %0d, expected %0d",
                                            rsp_mon.est_position, want.position));
               if (rsp_mon.running !== want.running)
                  report_mismatch($sformatf("running %0b, expected %0b",
                                            rsp_mon.running, want.running));
               if (rsp_mon.applied_level !== want.level)
                  report_mismatch($sformatf("applied_level %0d, expected %0d",
                                            rsp_mon.applied_level, want.level));
            end
         end
         if (req_mon.valid && req_mon.ready)
            outcome_queue.push_back(predict_outcome(req_mon.op, req_mon.drive_level,
                                                    req_mon.now_ms, req_mon.min_switch,
                                                    req_mon.max_switch));
         if (csr_we) begin
            case (csr_index)
               CSR_TRAVEL_MIN:    tmin_q = csr_wdata;
               CSR_TRAVEL_MAX:    tmax_q = csr_wdata;
               CSR_FULL_SPEED:    speed_q = csr_wdata[FS_W-1:0];
               CSR_COAST_TIME:    coast_q = csr_wdata[TIME_W-1:0];
               CSR_MIN_SPEED:     minfrac_q = csr_wdata[FRAC16_W-1:0];
               CSR_UPDATE_PERIOD: period_q = csr_wdata[TIME_W-1:0];
               CSR_SERVO_MODE:    servo_q = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding <= outcome_queue.size();
   end

endmodule

@@ test/motor_drive_dead_reckoning_unit_test.sv @@
// Testbench top for the motor drive dead-reckoning unit: drives directed and random
// items under changing register settings with random stalls on both channels.
// Depends on mddr_pkg, mddr_channels, the unit itself and drive_outcome_checker.
`timescale 1ns / 1ps

module motor_drive_dead_reckoning_unit_test;
   import mddr_pkg::*;

   localparam int RANDOM_ITEMS = 700;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 300;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   int fail_count, results_seen, outstanding;
   int items_sent, settings_used;
   bit no_idle;

   // register values of the current setting
   logic signed [DATA_W-1:0] cfg_tmin, cfg_tmax;
   logic [FS_W-1:0]          cfg_speed;
   logic [TIME_W-1:0]        cfg_coast, cfg_minfrac, cfg_period;
   logic                     cfg_servo;

   logic [DATA_W-1:0] clock_ms;

   mddr_req_if req_ch();
   mddr_rsp_if rsp_ch();

   motor_drive_dead_reckoning_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   drive_outcome_checker outcome_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .results_seen (results_seen),
      .outstanding  (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      return no_idle ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [DATA_W-1:0] pick_advance();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return '0;
         default: return $urandom_range(0, 2 * int'(cfg_period) + 2);
      endcase
   endfunction

   function automatic logic pick_switch();
      return $urandom_range(0, 15) == 0;
   endfunction

   task automatic write_csr(csr_idx_type idx, logic [DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_config();
      write_csr(CSR_TRAVEL_MIN, cfg_tmin);
      write_csr(CSR_TRAVEL_MAX, cfg_tmax);
      write_csr(CSR_FULL_SPEED, DATA_W'(cfg_speed));
      write_csr(CSR_COAST_TIME, DATA_W'(cfg_coast));
      write_csr(CSR_MIN_SPEED, DATA_W'(cfg_minfrac));
      write_csr(CSR_UPDATE_PERIOD, DATA_W'(cfg_period));
      write_csr(CSR_SERVO_MODE, DATA_W'(cfg_servo));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // hold the sender until every result has been taken
   task automatic wait_idle();
      if (req_ch.valid) req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_item(op_type op, logic signed [LEVEL_W-1:0] lvl,
                            logic [DATA_W-1:0] now, logic smin, logic smax);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         if (req_ch.valid) req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.drive_level <= lvl;
      req_ch.now_ms <= now;
      req_ch.min_switch <= smin;
      req_ch.max_switch <= smax;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // result side: random stall before each item
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            if (rsp_ch.ready) rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("ERROR: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int                        n;
      int                        directed_items;
      logic signed [LEVEL_W-1:0] lvl;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_TRAVEL_MIN;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_DRIVE;
      req_ch.drive_level <= '0;
      req_ch.now_ms <= '0;
      req_ch.min_switch <= 1'b0;
      req_ch.max_switch <= 1'b0;
      items_sent = 0;
      settings_used = 0;
      no_idle = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // bridge mode, ordinary travel range
      cfg_tmin = TRAVEL_MIN_RST;
      cfg_tmax = TRAVEL_MAX_RST;
      cfg_speed = 31'd655360;
      cfg_coast = 16'd500;
      cfg_minfrac = '0;
      cfg_period = UPDATE_PERIOD_RST;
      cfg_servo = 1'b0;
      apply_config();
      send_item(OP_DRIVE, 16'sd0, 32'd0, 1'b0, 1'b0);               // stop while stopped
      send_item(OP_DRIVE, LEVEL_MOST_NEG, 32'd10, 1'b0, 1'b0);      // blocked at lower end
      send_item(OP_DRIVE, 16'sd32767, 32'd1000, 1'b0, 1'b0);
      send_item(OP_TICK, 16'sd0, 32'd1050, 1'b0, 1'b0);             // inside update period
      send_item(OP_TICK, LEVEL_MOST_NEG, 32'd1100, 1'b0, 1'b0);
      send_item(OP_DRIVE, 16'sd16384, 32'd1200, 1'b0, 1'b0);        // level change en route
      send_item(OP_TICK, 16'sd0, 32'd61200, 1'b0, 1'b0);
      send_item(OP_DRIVE, 16'sd0, 32'd62000, 1'b0, 1'b0);           // stop with coast
      send_item(OP_TICK, 16'sd32767, 32'd62100, 1'b0, 1'b1);
      send_item(OP_DRIVE, 16'sd100, 32'd62200, 1'b0, 1'b0);         // blocked at upper end
      send_item(OP_DRIVE, -16'sd32767, 32'd62300, 1'b1, 1'b1);      // both switches
      send_item(OP_DRIVE, -16'sd20000, 32'hFFFF_FF00, 1'b0, 1'b1);
      send_item(OP_TICK, 16'sd0, 32'h0000_1000, 1'b0, 1'b0);        // clock wrap
      send_item(OP_DRIVE, 16'sd0, 32'h0000_2000, 1'b0, 1'b0);

      // servo mode, widest range, zero speed and zero period
      wait_idle();
      cfg_tmin = INT_LO;
      cfg_tmax = INT_HI;
      cfg_speed = '0;
      cfg_coast = 16'hFFFF;
      cfg_minfrac = 16'hFFFF;
      cfg_period = '0;
      cfg_servo = 1'b1;
      apply_config();
      send_item(OP_DRIVE, 16'sd32767, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_item(OP_TICK, 16'sd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_item(OP_DRIVE, -16'sd32767, 32'd5, 1'b0, 1'b0);
      send_item(OP_DRIVE, 16'sd0, 32'd10, 1'b0, 1'b0);
      send_item(OP_DRIVE, LEVEL_MOST_NEG, 32'd20, 1'b0, 1'b0);

      // top speed, longest coast and period, high minimum-speed gate
      wait_idle();
      cfg_tmin = -32'sd65536000;
      cfg_tmax = 32'sd65536000;
      cfg_speed = DIST_SAT;
      cfg_coast = 16'hFFFF;
      cfg_minfrac = 16'h8000;
      cfg_period = 16'hFFFF;
      cfg_servo = 1'b0;
      apply_config();
      send_item(OP_TICK, 16'sd0, 32'd100, 1'b1, 1'b0);
      send_item(OP_DRIVE, 16'sd1, 32'd200, 1'b0, 1'b0);             // below minimum speed
      send_item(OP_TICK, 16'sd0, 32'd65735, 1'b0, 1'b0);
      send_item(OP_DRIVE, 16'sd32767, 32'd70000, 1'b0, 1'b0);
      send_item(OP_TICK, 16'sd0, 32'd135535, 1'b0, 1'b0);           // distance saturates
      send_item(OP_DRIVE, 16'sd0, 32'd140000, 1'b0, 1'b0);
      directed_items = items_sent;

      clock_ms = 32'd200000;
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 3))
            0: begin
               cfg_tmin = INT_LO;
               cfg_tmax = INT_HI;
            end
            1: begin
               cfg_tmin = $urandom;
               cfg_tmax = $urandom;
            end
            default: begin
               cfg_tmin = -($urandom_range(0, 300) * 65536);
               cfg_tmax = cfg_tmin + $urandom_range(1, 600) * 65536;
            end
         endcase
         case ($urandom_range(0, 7))
            0: cfg_speed = '0;
            1: cfg_speed = DIST_SAT;
            2: cfg_speed = FS_W'($urandom);
            default: cfg_speed = FS_W'($urandom_range(1, 40) * 65536);
         endcase
         case ($urandom_range(0, 5))
            0: cfg_coast = '0;
            1: cfg_coast = 16'hFFFF;
            2: cfg_coast = TIME_W'($urandom);
            default: cfg_coast = TIME_W'($urandom_range(0, 3000));
         endcase
         cfg_minfrac = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
         case ($urandom_range(0, 7))
            0: cfg_period = '0;
            1: cfg_period = 16'hFFFF;
            2: cfg_period = TIME_W'($urandom);
            default: cfg_period = TIME_W'($urandom_range(1, 250));
         endcase
         cfg_servo = 1'($urandom_range(0, 1));
         apply_config();
         no_idle = ($urandom_range(0, 3) == 0);

         repeat ($urandom_range(8, 14)) begin
            if ($urandom_range(0, 4) == 0) begin
               // loose item: any field, clock may jump anywhere
               clock_ms = $urandom_range(0, 1) ? $urandom : clock_ms + pick_advance();
               send_item(op_type'($urandom_range(0, 1)), 16'($urandom), clock_ms,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
               // one journey: start, ticks with the odd level change, mostly a stop
               lvl = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(500, 32767));
               if ($urandom_range(0, 1)) lvl = -lvl;
               clock_ms += pick_advance();
               send_item(OP_DRIVE, lvl, clock_ms, pick_switch(), pick_switch());
               n = $urandom_range(1, 6);
               for (int k = 0; k < n; k++) begin
                  clock_ms += pick_advance();
                  if ($urandom_range(0, 4) == 0) begin
                     lvl = 16'($urandom_range(1, 32767));
                     if ($urandom_range(0, 1)) lvl = -lvl;
                     send_item(OP_DRIVE, lvl, clock_ms, pick_switch(), pick_switch());
                  end else begin
                     send_item(OP_TICK, 16'($urandom), clock_ms, pick_switch(), pick_switch());
                  end
               end
               if ($urandom_range(0, 6) != 0) begin
                  clock_ms += pick_advance();
                  send_item(OP_DRIVE, 16'sd0, clock_ms, pick_switch(), pick_switch());
               end
            end
            if ($urandom_range(0, 9) == 0) wait_idle();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d items (%0d directed) over %0d register settings;",
               items_sent, directed_items, settings_used);
      $display("%0d results compared, %0d mismatches.", results_seen, fail_count);
      if (fail_count == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ motor_drive_dead_reckoning_unit.f @@
rtl/mddr_pkg.sv
rtl/mddr_channels.sv
rtl/mddr_mul.sv
rtl/mddr_div.sv
rtl/motor_drive_dead_reckoning_unit.sv
test/drive_outcome_checker.sv
test/motor_drive_dead_reckoning_unit_test.sv
